[sv/dfp_pkg.sv]
package dfp_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_TYPE  = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;
   localparam logic [BYTE_W-1:0] FRAME_TYPE_RESET  = 8'h01;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_in_buffer;
   } req_type;

   typedef struct packed {
      logic        frame_found;
      logic        detected;
      logic [15:0] ball_x;
      logic [15:0] ball_y;
      logic [15:0] ball_radius;
      logic [15:0] tof_mm;
   } rsp_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] frame_type;
   } cfg_type;

endpackage

[sv/dfp_cell.sv]
module dfp_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   output logic [7:0] byte_out
);
   import dfp_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in_sel;

   assign byte_in_sel = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_sel;
   end

   assign byte_out = byte_ff;

endmodule

[sv/dfp_check.sv]
module dfp_check #(
   parameter int MSG_LEN = 13
) (
   input  logic [MSG_LEN-1:0][7:0] window,
   input  dfp_pkg::cfg_type        cfg,
   output logic                    is_frame,
   output dfp_pkg::rsp_type        frame_rsp
);
   import dfp_pkg::*;

   logic [BYTE_W-1:0] sum;

   always_comb begin
      sum = '0;
      for (int k = 2; k < MSG_LEN - 1; k++) begin
         sum = sum ^ window[k];
      end
   end

   assign is_frame = (window[0] == cfg.sync_first) && (window[1] == cfg.sync_second)
                     && (window[2] == cfg.frame_type) && (sum == window[MSG_LEN-1]);

   always_comb begin
      frame_rsp.frame_found = 1'b1;
      frame_rsp.detected    = (window[3] != '0);
      frame_rsp.ball_x      = {window[4], window[5]};
      frame_rsp.ball_y      = {window[6], window[7]};
      frame_rsp.ball_radius = {window[8], window[9]};
      frame_rsp.tof_mm      = {window[10], window[11]};
   end

endmodule

[sv/detection_frame_parser.sv]
// channel  ports                                 direction
// req      req_valid, req_stall, req_data        bytes in
// rsp      rsp_valid, rsp_stall, rsp_data        frame or not-found out
// csr      csr_we, csr_index, csr_wdata          register writes
//
// One request per cycle when not stalled; its result shows in the next cycle.
// The window is a row of byte cells; the check XORs bytes of the next window.
// Sync reset clears fill count, found flag, output valid; sets CSR defaults.
// req_stall is high while a result is held and rsp_stall is high.
module detection_frame_parser #(
   parameter int MSG_LEN = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dfp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dfp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [dfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_wdata
);
   import dfp_pkg::*;

   localparam int FILL_W = $clog2(MSG_LEN + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MSG_LEN);

   cfg_type           cfg_ff, cfg_in;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_inc;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic                    accept;
   logic [MSG_LEN-1:0][7:0] window;
   logic [MSG_LEN-1:0][7:0] window_next;
   logic                    is_frame;
   logic                    match;
   rsp_type                 frame_rsp;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   genvar g;
   generate
      for (g = 0; g < MSG_LEN; g++) begin : g_cell
         if (g == MSG_LEN - 1) begin : g_tail
            assign window_next[g] = req_data.rx_byte;
         end else begin : g_body
            assign window_next[g] = window[g+1];
         end
         dfp_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .byte_in  (window_next[g]),
            .byte_out (window[g])
         );
      end
   endgenerate

   dfp_check #(.MSG_LEN(MSG_LEN)) u_check (
      .window    (window_next),
      .cfg       (cfg_ff),
      .is_frame  (is_frame),
      .frame_rsp (frame_rsp)
   );

   assign fill_inc = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + FILL_W'(1);
   assign match    = !found_ff && (fill_inc == FILL_FULL) && is_frame;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_wdata;
            CSR_SYNC_SECOND: cfg_in.sync_second = csr_wdata;
            CSR_FRAME_TYPE:  cfg_in.frame_type  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (accept) begin
         fill_in  = fill_inc;
         found_in = found_ff || match;
         if (match || (req_data.last_in_buffer && !found_ff)) begin
            rsp_valid_in = 1'b1;
            rsp_in       = match ? frame_rsp : '0;
         end
         if (req_data.last_in_buffer) begin
            fill_in  = '0;
            found_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{sync_first: SYNC_FIRST_RESET, sync_second: SYNC_SECOND_RESET,
                           frame_type: FRAME_TYPE_RESET};
         fill_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         fill_ff      <= fill_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL) else $error("fill count beyond window length");

   a_found_full: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (fill_ff == FILL_FULL)) else $error("found flag with partial window");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_in_buffer |=> (fill_ff == '0) && !found_ff)
      else $error("buffer state not cleared at buffer end");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.frame_found |-> (rsp_ff == '0))
      else $error("not-found result with nonzero fields");
`endif

endmodule
